/* src/bps_pkg.sv */
// Shared constants, types and helpers of the byte pattern search block.
package bps_pkg;

   // Default sizing
   localparam int BPS_MAX_PATTERN   = 8;
   localparam int BPS_POSITION_BITS = 32;

   // Fixed field widths
   localparam int BYTE_BITS      = 8;
   localparam int PATTERN_BYTES  = 8;
   localparam int PATTERN_BITS   = PATTERN_BYTES * BYTE_BITS;
   localparam int LENGTH_BITS    = 4;
   localparam int OFFSET_BITS    = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   // Register indexes on the configuration channel
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_BYTES   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEXT_MODE       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CASE_SENSITIVE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REVERSE_PATTERN = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_OFFSET    = 3'd5;

   // Result codes
   localparam logic OUTCOME_FOUND     = 1'b0;
   localparam logic OUTCOME_NOT_FOUND = 1'b1;

   // Case folding of ASCII letters
   localparam logic [BYTE_BITS-1:0] UPPER_A   = 8'd65;
   localparam logic [BYTE_BITS-1:0] UPPER_Z   = 8'd90;
   localparam logic [BYTE_BITS-1:0] CASE_STEP = 8'd32;

   // Configuration register set
   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern_bytes;
      logic [LENGTH_BITS-1:0]  pattern_length;
      logic                    text_mode;
      logic                    case_sensitive;
      logic                    reverse_pattern;
      logic [OFFSET_BITS-1:0]  start_offset;
   } csr_regs_type;

   // Fold an upper-case letter to lower case when folding is on
   function automatic logic [BYTE_BITS-1:0] fold_byte(input logic [BYTE_BITS-1:0] b,
                                                      input logic fold_en);
      if (fold_en && (b >= UPPER_A) && (b <= UPPER_Z)) begin
         return b + CASE_STEP;
      end
      return b;
   endfunction

endpackage

/* src/bps_channels.sv */
// Channel interfaces of the byte pattern search block: request, response, CSR.
interface bps_req_if
   import bps_pkg::*;
   ;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface bps_rsp_if
   import bps_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic                   outcome;
   logic [OFFSET_BITS-1:0] match_start;
   logic [LENGTH_BITS-1:0] match_length;

   modport source (output valid, output outcome, output match_start, output match_length,
                   input ready);
   modport sink   (input valid, input outcome, input match_start, input match_length,
                   output ready);
endinterface

interface bps_csr_if
   import bps_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/bps_cell.sv */
// One window cell: holds a buffer byte, passes it on, compares it with the pattern.
module bps_cell
   import bps_pkg::*;
#(
   parameter int MAX_PATTERN = BPS_MAX_PATTERN
) (
   input  logic                                  clock,
   input  logic                                  shift_en,
   input  logic [BYTE_BITS-1:0]                  byte_in,
   output logic [BYTE_BITS-1:0]                  byte_out,
   input  logic                                  fold_en,
   input  logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] narrow_exp,
   input  logic [MAX_PATTERN-1:0][BYTE_BITS-1:0] wide_exp,
   output logic [MAX_PATTERN-1:0]                eq_narrow,
   output logic [MAX_PATTERN-1:0]                eq_wide,
   output logic                                  is_zero
);

   logic [BYTE_BITS-1:0] byte_ff;
   logic [BYTE_BITS-1:0] folded;

   // Advance the byte to the next cell on every accepted transaction
   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

   // Compare the byte this cell presents after the shift
   assign folded  = fold_byte(byte_in, fold_en);
   assign is_zero = (byte_in == '0);

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         eq_narrow[k] = (folded == narrow_exp[k]);
         eq_wide[k]   = (folded == wide_exp[k]);
      end
   end

endmodule

/* src/bps_match.sv */
// Match evaluator: combines cell compares per start distance and picks the lowest start.
module bps_match
   import bps_pkg::*;
#(
   parameter int MAX_PATTERN   = BPS_MAX_PATTERN,
   parameter int POSITION_BITS = BPS_POSITION_BITS,
   localparam int WinDepth     = 2 * MAX_PATTERN - 1,
   localparam int DistBits     = (WinDepth > 1) ? $clog2(WinDepth) : 1
) (
   input  logic [WinDepth-1:0][MAX_PATTERN-1:0] eq_narrow,
   input  logic [WinDepth-1:0][MAX_PATTERN-1:0] eq_wide,
   input  logic [WinDepth-1:0]                  is_zero,
   input  csr_regs_type                         cfg,
   input  logic [LENGTH_BITS-1:0]               len_eff,
   input  logic [POSITION_BITS-1:0]             position,
   input  logic                                 search_done,
   input  logic                                 last_byte,
   output logic                                 found,
   output logic [DistBits-1:0]                  hit_lag
);

   localparam int WideBits = ((POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS) + 1;

   logic [WideBits-1:0]   pos_minus_off;
   logic                  before_offset;
   logic [LENGTH_BITS:0]  main_dist;
   logic                  search_en;
   logic [WinDepth-1:0]   narrow_ok;
   logic [WinDepth-1:0]   wide_ok;
   logic [WinDepth-1:0]   start_ok;

   // Distance of the candidate that the newest byte completes
   assign main_dist = cfg.text_mode ? (({1'b0, len_eff} << 1) - 5'd2)
                                    : ({1'b0, len_eff} - 5'd1);
   assign search_en = !search_done && (len_eff != '0);

   // Start at position-d is legal when position >= d and position-d >= start_offset
   assign pos_minus_off = WideBits'(position) - WideBits'(cfg.start_offset);
   assign before_offset = pos_minus_off[WideBits-1];

   always_comb begin
      for (int d = 0; d < WinDepth; d++) begin
         start_ok[d] = (position >= POSITION_BITS'(d)) && !before_offset &&
                       (pos_minus_off[WideBits-2:0] >= (WideBits-1)'(d));
      end
   end

   // Narrow match: consecutive bytes
   always_comb begin
      for (int d = 0; d < WinDepth; d++) begin
         narrow_ok[d] = ((d + 1) >= int'(len_eff));
         for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < int'(len_eff)) begin
               if (d >= k) begin
                  narrow_ok[d] = narrow_ok[d] && eq_narrow[d-k][k];
               end else begin
                  narrow_ok[d] = 1'b0;
               end
            end
         end
      end
   end

   // Wide match: characters two bytes apart with a zero byte in between
   always_comb begin
      for (int d = 0; d < WinDepth; d++) begin
         wide_ok[d] = cfg.text_mode && ((d + 2) >= 2 * int'(len_eff)) && eq_wide[d][0];
         for (int k = 1; k < MAX_PATTERN; k++) begin
            if (k < int'(len_eff)) begin
               if (d >= 2 * k) begin
                  wide_ok[d] = wide_ok[d] && eq_wide[d-2*k][k] && is_zero[d-2*k+1];
               end else begin
                  wide_ok[d] = 1'b0;
               end
            end
         end
      end
   end

   // Pick the largest distance that matches: that is the lowest start
   always_comb begin
      found   = 1'b0;
      hit_lag = '0;
      for (int d = 0; d < WinDepth; d++) begin
         if (search_en && start_ok[d] && (narrow_ok[d] || wide_ok[d]) &&
             ((LENGTH_BITS+1)'(d) <= main_dist) &&
             (last_byte || ((LENGTH_BITS+1)'(d) == main_dist))) begin
            found   = 1'b1;
            hit_lag = DistBits'(d);
         end
      end
   end

endmodule

/* src/byte_pattern_search_top.sv */
// Top level of the byte pattern search block: CSRs, cell chain, evaluator, response register.
//
//   channel   direction  payload                                  handshake
//   req_chan  in         data_byte, end_of_buffer                 valid / ready
//   rsp_chan  out        outcome, match_start, match_length       valid / ready
//   csr_chan  in         index, data                              valid / ready (always ready)
//
// One byte per cycle, back to back while req_chan is not stalled; the window compare, match
// evaluation and the position count all finish in the accept cycle, and the registered response shows in the next.
// The response register frees itself in the cycle it is taken, so req_chan only stalls
// while a response waits on rsp_chan with ready low.
// Synchronous reset clears CSRs (reverse_pattern to 1), position, done flag and the
// response valid; the window bytes need no reset.
module byte_pattern_search_top
   import bps_pkg::*;
#(
   parameter int MAX_PATTERN   = BPS_MAX_PATTERN,
   parameter int POSITION_BITS = BPS_POSITION_BITS
) (
   input  logic       clock,
   input  logic       reset,
   bps_req_if.sink    req_chan,
   bps_rsp_if.source  rsp_chan,
   bps_csr_if.sink    csr_chan
);

   localparam int WinDepth = 2 * MAX_PATTERN - 1;
   localparam int DistBits = (WinDepth > 1) ? $clog2(WinDepth) : 1;
   localparam int StartBits = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

   csr_regs_type                 csr_ff, csr_in;
   logic [POSITION_BITS-1:0]     pos_ff, pos_in;
   logic                         done_ff, done_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         outcome_ff, outcome_in;
   logic [OFFSET_BITS-1:0]       start_ff, start_in;
   logic [LENGTH_BITS-1:0]       length_ff, length_in;

   logic                         accept;
   logic                         last_byte;
   logic                         fold_en;
   logic                         rev_en;
   logic [LENGTH_BITS-1:0]       len_eff;
   logic [PATTERN_BYTES-1:0][BYTE_BITS-1:0] pat_arr;
   logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]   narrow_exp;
   logic [MAX_PATTERN-1:0][BYTE_BITS-1:0]   wide_exp;
   logic [WinDepth-1:0][BYTE_BITS-1:0]      chain;
   logic [WinDepth-1:0][MAX_PATTERN-1:0]    eq_narrow;
   logic [WinDepth-1:0][MAX_PATTERN-1:0]    eq_wide;
   logic [WinDepth-1:0]                     is_zero;
   logic                         found;
   logic [DistBits-1:0]          hit_lag;
   logic                         produce;
   logic [StartBits-1:0]         start_wide;

   // Handshakes
   assign accept         = req_chan.valid && req_chan.ready;
   assign last_byte      = req_chan.end_of_buffer;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign csr_chan.ready = 1'b1;

   // CSR writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PATTERN_BYTES:   csr_in.pattern_bytes   = csr_chan.data;
            CSR_PATTERN_LENGTH:  csr_in.pattern_length  = csr_chan.data[LENGTH_BITS-1:0];
            CSR_TEXT_MODE:       csr_in.text_mode       = csr_chan.data[0];
            CSR_CASE_SENSITIVE:  csr_in.case_sensitive  = csr_chan.data[0];
            CSR_REVERSE_PATTERN: csr_in.reverse_pattern = csr_chan.data[0];
            CSR_START_OFFSET:    csr_in.start_offset    = csr_chan.data[OFFSET_BITS-1:0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff                 <= '0;
         csr_ff.reverse_pattern <= 1'b1;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Effective length and expected bytes for each pattern offset
   assign len_eff = (csr_ff.pattern_length > LENGTH_BITS'(MAX_PATTERN))
                    ? LENGTH_BITS'(MAX_PATTERN) : csr_ff.pattern_length;
   assign fold_en = csr_ff.text_mode && !csr_ff.case_sensitive;
   assign rev_en  = !csr_ff.text_mode && csr_ff.reverse_pattern;
   assign pat_arr = csr_ff.pattern_bytes;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         wide_exp[k]   = pat_arr[3'(k)];
         narrow_exp[k] = rev_en ? pat_arr[3'(len_eff - 4'd1 - 4'(k))] : pat_arr[3'(k)];
      end
   end

   // Chain of window cells, newest byte enters cell zero
   assign chain[0] = req_chan.data_byte;

   for (genvar i = 0; i < WinDepth; i++) begin : g_cell
      if (i < WinDepth - 1) begin : g_link
         bps_cell #(.MAX_PATTERN(MAX_PATTERN)) u_cell (
            .clock      (clock),
            .shift_en   (accept),
            .byte_in    (chain[i]),
            .byte_out   (chain[i+1]),
            .fold_en    (fold_en),
            .narrow_exp (narrow_exp),
            .wide_exp   (wide_exp),
            .eq_narrow  (eq_narrow[i]),
            .eq_wide    (eq_wide[i]),
            .is_zero    (is_zero[i])
         );
      end else begin : g_tail
         bps_cell #(.MAX_PATTERN(MAX_PATTERN)) u_cell (
            .clock      (clock),
            .shift_en   (accept),
            .byte_in    (chain[i]),
            .byte_out   (),
            .fold_en    (fold_en),
            .narrow_exp (narrow_exp),
            .wide_exp   (wide_exp),
            .eq_narrow  (eq_narrow[i]),
            .eq_wide    (eq_wide[i]),
            .is_zero    (is_zero[i])
         );
      end
   end

   // Evaluate all start distances for this byte
   bps_match #(
      .MAX_PATTERN   (MAX_PATTERN),
      .POSITION_BITS (POSITION_BITS)
   ) u_match (
      .eq_narrow   (eq_narrow),
      .eq_wide     (eq_wide),
      .is_zero     (is_zero),
      .cfg         (csr_ff),
      .len_eff     (len_eff),
      .position    (pos_ff),
      .search_done (done_ff),
      .last_byte   (last_byte),
      .found       (found),
      .hit_lag     (hit_lag)
   );

   assign produce    = found || (last_byte && !done_ff);
   assign start_wide = StartBits'(pos_ff) - StartBits'(hit_lag);

   // Advance position and done flag; drop both at the end of the buffer
   always_comb begin
      pos_in  = pos_ff;
      done_in = done_ff;
      if (accept) begin
         if (last_byte) begin
            pos_in  = '0;
            done_in = 1'b0;
         end else begin
            pos_in  = pos_ff + 1'b1;
            done_in = done_ff || found;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

   // Response register: load on a result, release when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      outcome_in   = outcome_ff;
      start_in     = start_ff;
      length_in    = length_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && produce) begin
         rsp_valid_in = 1'b1;
         if (found) begin
            outcome_in = OUTCOME_FOUND;
            start_in   = start_wide[OFFSET_BITS-1:0];
            length_in  = len_eff;
         end else begin
            outcome_in = OUTCOME_NOT_FOUND;
            start_in   = '0;
            length_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
      start_ff   <= start_in;
      length_ff  <= length_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.outcome      = outcome_ff;
   assign rsp_chan.match_start  = start_ff;
   assign rsp_chan.match_length = length_ff;

   // The last byte of a buffer restarts the scan
   a_buffer_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> (pos_ff == '0) && !done_ff)
      else $error("scan state not cleared after end of buffer");

   // No second result inside a buffer once a match was reported
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (accept && done_ff) |-> !produce)
      else $error("result produced after a match in the same buffer");

   // A match mid-buffer marks the buffer as done
   a_match_marks_done: assert property (@(posedge clock) disable iff (reset)
      (accept && found && !last_byte) |=> done_ff)
      else $error("match not recorded in done flag");

endmodule

/* tb/byte_pattern_search_top_tb.sv */
// Self-checking testbench of byte_pattern_search_top: random buffers checked against a search predictor.
`timescale 1ns / 1ps

module byte_pattern_search_top_tb
   import bps_pkg::*;
   ;

   localparam int WINDOW_DEPTH   = 2 * BPS_MAX_PATTERN - 1;
   localparam int IDLE_PCT       = 17;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_BYTES    = 125;
   localparam int SETTLE_CYCLES  = 4;

   // Register slots that decode to nothing
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 end_of_buffer;
   } buffer_byte_type;

   typedef struct packed {
      logic                   outcome;
      logic [OFFSET_BITS-1:0] match_start;
      logic [LENGTH_BITS-1:0] match_length;
   } search_report_type;

   typedef logic [BYTE_BITS-1:0] byte_list_type [$];

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   int   mismatches = 0;

   buffer_byte_type   pending_bytes [$];
   search_report_type predicted_reports [$];

   // Predictor copy of the registers and the scan state
   csr_regs_type         cfg;
   logic [BYTE_BITS-1:0] window [WINDOW_DEPTH];
   logic [31:0]          position;
   bit                   done;

   bps_req_if req_if ();
   bps_rsp_if rsp_if ();
   bps_csr_if csr_if ();

   byte_pattern_search_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("byte_pattern_search_top regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [BYTE_BITS-1:0] folded(input logic [BYTE_BITS-1:0] b);
      if (cfg.text_mode && !cfg.case_sensitive && b >= UPPER_A && b <= UPPER_Z) begin
         return b + CASE_STEP;
      end
      return b;
   endfunction

   // Byte at offset k of a start lying lag bytes behind the newest one
   function automatic logic [BYTE_BITS-1:0] window_byte(input int lag, input int k);
      int i;
      i = lag - k;
      return (i >= 0 && i < WINDOW_DEPTH) ? window[i] : '0;
   endfunction

   function automatic bit pattern_at(input int lag, input int len);
      logic [BYTE_BITS-1:0] want;
      bit ok;
      if (len == 0) begin
         return 1'b0;
      end
      // Narrow compare, reversed only in binary mode
      if (lag >= len - 1) begin
         ok = 1'b1;
         for (int k = 0; k < len; k++) begin
            if (!cfg.text_mode && cfg.reverse_pattern) begin
               want = cfg.pattern_bytes[8*(len-1-k) +: 8];
            end else begin
               want = cfg.pattern_bytes[8*k +: 8];
            end
            if (folded(window_byte(lag, k)) != want) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            return 1'b1;
         end
      end
      // Wide compare: characters at even offsets, zero bytes between them
      if (cfg.text_mode && lag >= 2 * len - 2) begin
         if (folded(window_byte(lag, 0)) != cfg.pattern_bytes[7:0]) begin
            return 1'b0;
         end
         for (int k = 1; k < len; k++) begin
            if (window_byte(lag, 2 * k - 1) != '0) begin
               return 1'b0;
            end
            if (folded(window_byte(lag, 2 * k)) != cfg.pattern_bytes[8*k +: 8]) begin
               return 1'b0;
            end
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit start_matches(input int lag, input int len);
      logic [31:0] first;
      if (position < 32'(lag)) begin
         return 1'b0;
      end
      first = position - 32'(lag);
      if (first < cfg.start_offset) begin
         return 1'b0;
      end
      return pattern_at(lag, len);
   endfunction

   // Advance the scan by one byte; returns 1 when the byte yields a report
   function automatic bit scan_byte(input logic [BYTE_BITS-1:0] value, input logic last,
                                    output search_report_type report);
      int len;
      int span;
      int lag;
      int d;
      bit found;
      bit has_report;
      len = (cfg.pattern_length > BPS_MAX_PATTERN) ? BPS_MAX_PATTERN
                                                   : int'(cfg.pattern_length);
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
         window[i] = window[i-1];
      end
      window[0] = value;
      found = 1'b0;
      has_report = 1'b0;
      lag = 0;
      report = '0;

      if (!done && len > 0) begin
         span = cfg.text_mode ? 2 * len - 1 : len;
         if (start_matches(span - 1, len)) begin
            found = 1'b1;
            lag = span - 1;
         end else if (last) begin
            // Try the starts that can no longer complete, lowest first
            d = span - 1;
            while (d > 0) begin
               d--;
               if (start_matches(d, len)) begin
                  found = 1'b1;
                  lag = d;
                  break;
               end
            end
         end
      end

      if (found) begin
         report.outcome = OUTCOME_FOUND;
         report.match_start = position - 32'(lag);
         report.match_length = LENGTH_BITS'(len);
         done = 1'b1;
         has_report = 1'b1;
      end else if (last && !done) begin
         report.outcome = OUTCOME_NOT_FOUND;
         has_report = 1'b1;
      end

      if (last) begin
         position = '0;
         done = 1'b0;
         foreach (window[i]) window[i] = '0;
      end else begin
         position = position + 32'd1;
      end
      return has_report;
   endfunction

   function automatic void record_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                           input logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_PATTERN_BYTES:   cfg.pattern_bytes   = value;
         CSR_PATTERN_LENGTH:  cfg.pattern_length  = value[LENGTH_BITS-1:0];
         CSR_TEXT_MODE:       cfg.text_mode       = value[0];
         CSR_CASE_SENSITIVE:  cfg.case_sensitive  = value[0];
         CSR_REVERSE_PATTERN: cfg.reverse_pattern = value[0];
         CSR_START_OFFSET:    cfg.start_offset    = value[OFFSET_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------- channels

   // Feed buffer bytes, idling at random unless in a steady stretch
   always @(posedge clock) begin : drive_bytes
      buffer_byte_type next_byte;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_bytes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_byte = pending_bytes.pop_front();
            req_if.valid         <= 1'b1;
            req_if.data_byte     <= next_byte.data_byte;
            req_if.end_of_buffer <= next_byte.end_of_buffer;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Stall the report channel at random
   always @(posedge clock) begin : pace_reports
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Check each report taken, then predict from each byte taken
   always @(posedge clock) begin : watch_channels
      search_report_type want;
      search_report_type report;
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (predicted_reports.size() == 0) begin
               $error("report with none predicted: outcome %0d start 0x%0h length %0d",
                      rsp_if.outcome, rsp_if.match_start, rsp_if.match_length);
               mismatches++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("outcome", want.outcome, rsp_if.outcome);
               check_field("match_start", want.match_start, rsp_if.match_start);
               check_field("match_length", want.match_length, rsp_if.match_length);
            end
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            if (scan_byte(req_if.data_byte, req_if.end_of_buffer, report)) begin
               predicted_reports.insert(predicted_reports.size(), report);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      record_register(idx, value);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every byte is taken and every report has come back
   task automatic settle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_if.valid || predicted_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_bytes(input byte_list_type bytes, input bit closes);
      buffer_byte_type item;
      foreach (bytes[i]) begin
         item.data_byte = bytes[i];
         item.end_of_buffer = closes && (i == bytes.size() - 1);
         pending_bytes.insert(pending_bytes.size(), item);
      end
   endtask

   // One register setting followed by buffers that mostly hold a planted pattern
   task automatic random_phase(input int phase);
      logic [CSR_DATA_BITS-1:0] pat;
      logic [OFFSET_BITS-1:0]   offset;
      logic [BYTE_BITS-1:0]     c;
      byte_list_type bytes;
      byte_list_type seq;
      int raw_len;
      int eff;
      int blen;
      int at;
      int produced;
      bit text;
      bit sensitive;
      bit rev;
      bit wide;

      text = $urandom_range(1);
      sensitive = $urandom_range(1);
      rev = $urandom_range(1);
      case ($urandom_range(9))
         0: raw_len = 0;
         1: raw_len = $urandom_range(15, 9);
         default: raw_len = $urandom_range(8, 1);
      endcase
      case ($urandom_range(9))
         0: offset = '1;
         1: offset = $urandom();
         2, 3, 4: offset = $urandom_range(30, 1);
         default: offset = '0;
      endcase
      // Pin the extremes on the first few settings
      case (phase)
         0: begin raw_len = BPS_MAX_PATTERN; offset = '0; end
         1: begin raw_len = 15; offset = '1; end
         2: begin raw_len = 1; text = 1'b1; sensitive = 1'b0; end
         3: raw_len = 0;
         default: ;
      endcase
      eff = (raw_len > BPS_MAX_PATTERN) ? BPS_MAX_PATTERN : raw_len;

      for (int k = 0; k < PATTERN_BYTES; k++) begin
         if (!text) begin
            pat[8*k +: 8] = 8'($urandom_range(255));
         end else begin
            case ($urandom_range(9))
               0: pat[8*k +: 8] = 8'($urandom_range(UPPER_Z, UPPER_A));
               1, 2: pat[8*k +: 8] = 8'($urandom_range(255));
               default: pat[8*k +: 8] = 8'($urandom_range(UPPER_Z + CASE_STEP,
                                                          UPPER_A + CASE_STEP));
            endcase
         end
      end

      write_register(CSR_PATTERN_BYTES, pat);
      write_register(CSR_PATTERN_LENGTH, {$urandom(), 28'($urandom()), 4'(raw_len)});
      write_register(CSR_TEXT_MODE, {$urandom(), 31'($urandom()), text});
      write_register(CSR_CASE_SENSITIVE, {$urandom(), 31'($urandom()), sensitive});
      write_register(CSR_REVERSE_PATTERN, {$urandom(), 31'($urandom()), rev});
      write_register(CSR_START_OFFSET, {$urandom(), offset});

      steady = (phase == 5 || phase == 6);
      produced = 0;
      while (produced < PHASE_BYTES) begin
         blen = ($urandom_range(9) == 0) ? $urandom_range(120, 25) : $urandom_range(24, 1);
         bytes.delete();
         // Filler biased toward pattern bytes, zeros and letters
         for (int i = 0; i < blen; i++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: c = 8'($urandom_range(255));
               4, 5, 6: c = pat[8*$urandom_range(7) +: 8];
               7: c = '0;
               default: c = $urandom_range(1) ? 8'($urandom_range(UPPER_Z, UPPER_A))
                                              : 8'($urandom_range(UPPER_Z + CASE_STEP,
                                                                  UPPER_A + CASE_STEP));
            endcase
            bytes.insert(bytes.size(), c);
         end
         // Plant the pattern, narrow or wide, with letters flipped where folding allows
         if (eff > 0 && $urandom_range(4) != 0) begin
            seq.delete();
            wide = text && $urandom_range(1);
            for (int k = 0; k < eff; k++) begin
               c = (!text && rev) ? pat[8*(eff-1-k) +: 8] : pat[8*k +: 8];
               if (text && !sensitive && c >= UPPER_A + CASE_STEP &&
                   c <= UPPER_Z + CASE_STEP && $urandom_range(1)) begin
                  c = c - CASE_STEP;
               end
               if (wide && k > 0) begin
                  seq.insert(seq.size(), 8'h00);
               end
               seq.insert(seq.size(), c);
            end
            if ($urandom_range(5) == 0) begin
               at = $urandom_range(seq.size() - 1);
               seq[at] = seq[at] ^ (8'd1 << $urandom_range(7));
            end
            at = $urandom_range(blen - 1);
            foreach (seq[i]) begin
               if (at + i < blen) bytes[at + i] = seq[i];
            end
         end
         queue_bytes(bytes, 1'b1);
         produced += blen;
      end
      settle();
      steady = 1'b0;
   endtask

   initial begin : run_search
      int spin;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.end_of_buffer = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      cfg = '0;
      cfg.reverse_pattern = 1'b1;
      position = '0;
      done = 1'b0;
      foreach (window[i]) window[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Unused register slots must leave the setting alone
      write_register(CSR_SPARE_LO, {$urandom(), $urandom()});
      write_register(CSR_SPARE_HI, {$urandom(), $urandom()});

      // Zero length after reset: not found at the last byte
      queue_bytes('{8'h00, 8'hFF}, 1'b1);
      settle();

      // Binary, reversed by default; the byte after the match stays silent
      write_register(CSR_PATTERN_BYTES, {$urandom(), 8'($urandom()), 24'h030201});
      write_register(CSR_PATTERN_LENGTH, {$urandom(), 28'($urandom()), 4'd3});
      queue_bytes('{8'h80, 8'h03, 8'h02, 8'h01, 8'h7F}, 1'b1);
      settle();

      // Text "abc", folded, wide match closing on the last byte
      write_register(CSR_PATTERN_BYTES, {$urandom(), 8'($urandom()), 24'h636261});
      write_register(CSR_TEXT_MODE, {$urandom(), 31'($urandom()), 1'b1});
      queue_bytes('{8'h41, 8'h00, 8'h62, 8'h00, 8'h43}, 1'b1);
      settle();

      // Turn on case sensitivity in the middle of a buffer
      queue_bytes('{8'h7A, 8'h41}, 1'b0);
      settle();
      write_register(CSR_CASE_SENSITIVE, {$urandom(), 31'($urandom()), 1'b1});
      queue_bytes('{8'h62, 8'h43}, 1'b1);
      settle();

      // Oversized length acts as the full eight bytes, in plain order
      write_register(CSR_TEXT_MODE, {$urandom(), 31'($urandom()), 1'b0});
      write_register(CSR_REVERSE_PATTERN, {$urandom(), 31'($urandom()), 1'b0});
      write_register(CSR_PATTERN_LENGTH, {$urandom(), 28'($urandom()), 4'hF});
      write_register(CSR_PATTERN_BYTES, {$urandom(), $urandom()});
      begin
         byte_list_type whole;
         for (int k = 0; k < PATTERN_BYTES; k++) begin
            whole.insert(whole.size(), cfg.pattern_bytes[8*k +: 8]);
         end
         queue_bytes(whole, 1'b1);
      end
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_phase(phase);
      end

      // Drain, with a bound on reports that never come
      do @(posedge clock); while (pending_bytes.size() != 0 || req_if.valid);
      spin = 0;
      while (predicted_reports.size() != 0 && spin < 1000) begin
         @(posedge clock);
         spin++;
      end
      repeat (8) @(posedge clock);
      if (predicted_reports.size() != 0) begin
         $error("%0d predicted reports never arrived", predicted_reports.size());
         mismatches++;
      end

      if (mismatches == 0) begin
         $display("byte_pattern_search_top regression: pass");
      end else begin
         $display("byte_pattern_search_top regression: fail");
      end
      $finish;
   end

endmodule
